>>> hw/rtl/key_matrix_scan_charlieplex_leds_macros.svh
// Assertion macros shared by the keypad scanner RTL.
`ifndef KEY_MATRIX_SCAN_CHARLIEPLEX_LEDS_MACROS_SVH
`define KEY_MATRIX_SCAN_CHARLIEPLEX_LEDS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMSC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KMSC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/kmsc_pkg.sv
// Shared widths, register codes and the LED pin pair table of the keypad scanner.
package kmsc_pkg;

    localparam int MAX_BUTTONS     = 12;
    localparam int DEF_NUM_BUTTONS = 8;

    localparam int ROW_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int COL_W   = 4;
    localparam int PIN_W   = 6;
    localparam int LEDS_W  = 12;
    localparam int ACT_W   = 8;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    // Register index codes, taken from byte address bit 2.
    typedef enum logic {
        REG_ACTIVE_BUTTON = 1'b0,
        REG_RESERVED      = 1'b1
    } reg_index_t;

    localparam logic [ACT_W-1:0] ACTIVE_NONE = 8'hff;

    typedef logic [PIN_W-1:0] pin_mask_t;

    typedef struct packed {
        pin_mask_t pin_a;
        pin_mask_t pin_b;
    } pin_pair_t;

    // Charlieplex pin pair of each slot; pin p maps to bit p-1.
    function automatic pin_pair_t pin_pair(input logic [SLOT_W-1:0] slot);
        pin_pair_t pp;
        pp = '0;
        case (slot)
            4'd0:    pp = '{pin_a: 6'b000001, pin_b: 6'b000010};
            4'd1:    pp = '{pin_a: 6'b000001, pin_b: 6'b000100};
            4'd2:    pp = '{pin_a: 6'b000001, pin_b: 6'b001000};
            4'd3:    pp = '{pin_a: 6'b000010, pin_b: 6'b000100};
            4'd4:    pp = '{pin_a: 6'b000010, pin_b: 6'b001000};
            4'd5:    pp = '{pin_a: 6'b000010, pin_b: 6'b010000};
            4'd6:    pp = '{pin_a: 6'b000100, pin_b: 6'b001000};
            4'd7:    pp = '{pin_a: 6'b000100, pin_b: 6'b010000};
            4'd8:    pp = '{pin_a: 6'b000100, pin_b: 6'b100000};
            4'd9:    pp = '{pin_a: 6'b001000, pin_b: 6'b010000};
            4'd10:   pp = '{pin_a: 6'b001000, pin_b: 6'b100000};
            4'd11:   pp = '{pin_a: 6'b010000, pin_b: 6'b100000};
            default: pp = '0;
        endcase
        return pp;
    endfunction

endpackage

>>> hw/rtl/kmsc_if.sv
// Valid/ready channel interfaces for scan input words and scan result words.
interface kmsc_in_if;
    logic                      valid;
    logic                      ready;
    logic [kmsc_pkg::ROW_W-1:0] row_levels;

    modport source (output valid, output row_levels, input ready);
    modport sink   (input valid, input row_levels, output ready);
endinterface

interface kmsc_out_if;
    logic                        valid;
    logic                        ready;
    logic [kmsc_pkg::SLOT_W-1:0] scanned_slot;
    logic                        toggled;
    logic [kmsc_pkg::COL_W-1:0]  column_drive;
    logic [kmsc_pkg::PIN_W-1:0]  led_pin_enable;
    logic [kmsc_pkg::PIN_W-1:0]  led_pin_level;
    logic [kmsc_pkg::LEDS_W-1:0] selected_leds;

    modport source (
        output valid, output scanned_slot, output toggled, output column_drive,
        output led_pin_enable, output led_pin_level, output selected_leds,
        input  ready
    );
    modport sink (
        input  valid, input scanned_slot, input toggled, input column_drive,
        input  led_pin_enable, input led_pin_level, input selected_leds,
        output ready
    );
endinterface

>>> hw/rtl/key_matrix_scan_charlieplex_leds.sv
// Keypad matrix scanner with charlieplexed LED driver: top level.
//
//  Channel    Dir   Handshake        Payload
//  scan_in    in    valid/ready      row_levels
//  scan_out   out   valid/ready      scanned_slot, toggled, column_drive,
//                                    led_pin_enable, led_pin_level, selected_leds
//  APB        in    psel/penable     active_button at byte address 0
//
// One word per cycle sustained while scan_out is ready; an accepted word passes
// through the input register, then the result register.
// The slot counter and LED state update as a word moves into the result register.
// Reset is asynchronous and active low; it clears state and empties both stages.
// A stalled result holds the result register, and the input register keeps taking
// one more word until it is full as well.
module key_matrix_scan_charlieplex_leds #(
    parameter int NUM_BUTTONS = kmsc_pkg::DEF_NUM_BUTTONS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    kmsc_in_if.sink                       scan_in,
    kmsc_out_if.source                    scan_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [kmsc_pkg::PDATA_W-1:0]  pwdata,
    output logic [kmsc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

`include "key_matrix_scan_charlieplex_leds_macros.svh"

    localparam logic [kmsc_pkg::SLOT_W-1:0] LAST_SLOT = kmsc_pkg::SLOT_W'(NUM_BUTTONS - 1);

    logic [kmsc_pkg::ACT_W-1:0]  active_button_reg;
    logic [kmsc_pkg::SLOT_W-1:0] scan_slot_reg;
    logic [kmsc_pkg::LEDS_W-1:0] last_pressed_reg;
    logic [kmsc_pkg::LEDS_W-1:0] led_bits_reg;
    logic                        in_valid_reg;
    logic [kmsc_pkg::ROW_W-1:0]  row_reg;
    logic                        out_valid_reg;

    logic [kmsc_pkg::SLOT_W-1:0] slot_reg;
    logic                        toggled_reg;
    logic [kmsc_pkg::COL_W-1:0]  column_reg;
    logic [kmsc_pkg::PIN_W-1:0]  enable_reg;
    logic [kmsc_pkg::PIN_W-1:0]  level_reg;

    logic [kmsc_pkg::SLOT_W-1:0] slot_c;
    logic [kmsc_pkg::SLOT_W-1:0] scan_slot_next;
    logic [kmsc_pkg::LEDS_W-1:0] slot_bit;
    logic                        pressed;
    logic                        new_press;
    logic [kmsc_pkg::LEDS_W-1:0] last_pressed_next;
    logic [kmsc_pkg::LEDS_W-1:0] led_bits_next;
    logic [kmsc_pkg::COL_W-1:0]  column_next;
    logic [kmsc_pkg::PIN_W-1:0]  enable_next;
    logic [kmsc_pkg::PIN_W-1:0]  level_next;
    kmsc_pkg::pin_pair_t         pair;
    kmsc_pkg::reg_index_t        reg_index;
    logic                        cfg_write;
    logic                        advance;
    logic                        in_take;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_index = kmsc_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready
                       && (reg_index == kmsc_pkg::REG_ACTIVE_BUTTON);

    always_comb
    begin
        unique case (reg_index)
            kmsc_pkg::REG_ACTIVE_BUTTON:
                prdata = {{(kmsc_pkg::PDATA_W - kmsc_pkg::ACT_W){1'b0}}, active_button_reg};
            default:
                prdata = '0;
        endcase
    end

    // Handshake.
    assign advance       = in_valid_reg && (!out_valid_reg || scan_out.ready);
    assign scan_in.ready = !in_valid_reg || advance;
    assign in_take       = scan_in.valid && scan_in.ready;

    // Scan tick logic.
    always_comb
    begin
        slot_c = (scan_slot_reg <= LAST_SLOT) ? scan_slot_reg : '0;
        scan_slot_next = (slot_c == LAST_SLOT) ? '0 : slot_c + 1'b1;
        slot_bit = kmsc_pkg::LEDS_W'(1) << slot_c;

        // Rows are active low; the row is the slot's upper two bits.
        case (slot_c[3:2])
            2'd0:    pressed = !row_reg[0];
            2'd1:    pressed = !row_reg[1];
            2'd2:    pressed = !row_reg[2];
            default: pressed = 1'b0;
        endcase

        new_press = pressed && !(|(last_pressed_reg & slot_bit));
        led_bits_next = led_bits_reg ^ (new_press ? slot_bit : '0);
        last_pressed_next = pressed ? (last_pressed_reg | slot_bit)
                                    : (last_pressed_reg & ~slot_bit);

        pair = kmsc_pkg::pin_pair(slot_c);
        if (|(led_bits_next & slot_bit))
        begin
            enable_next = pair.pin_a | pair.pin_b;
            level_next  = ({4'b0000, slot_c} == active_button_reg) ? pair.pin_a : pair.pin_b;
        end
        else
        begin
            enable_next = '0;
            level_next  = '0;
        end

        column_next = ~(kmsc_pkg::COL_W'(1) << scan_slot_next[1:0]);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_button_reg <= kmsc_pkg::ACTIVE_NONE;
            scan_slot_reg     <= '0;
            last_pressed_reg  <= '0;
            led_bits_reg      <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                active_button_reg <= pwdata[kmsc_pkg::ACT_W-1:0];
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                scan_slot_reg    <= scan_slot_next;
                last_pressed_reg <= last_pressed_next;
                led_bits_reg     <= led_bits_next;
                out_valid_reg    <= 1'b1;
            end
            else if (scan_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            row_reg <= scan_in.row_levels;
        end
        if (advance)
        begin
            slot_reg    <= slot_c;
            toggled_reg <= new_press;
            column_reg  <= column_next;
            enable_reg  <= enable_next;
            level_reg   <= level_next;
        end
    end

    assign scan_out.valid          = out_valid_reg;
    assign scan_out.scanned_slot   = slot_reg;
    assign scan_out.toggled        = toggled_reg;
    assign scan_out.column_drive   = column_reg;
    assign scan_out.led_pin_enable = enable_reg;
    assign scan_out.led_pin_level  = level_reg;
    assign scan_out.selected_leds  = led_bits_reg;

    `KMSC_ASSERT_IMP(a_slot_range, clk, rst_n, 1'b1, scan_slot_reg <= LAST_SLOT,
        "slot counter left the button range")

    `KMSC_ASSERT_NXT(a_toggle_flips, clk, rst_n, advance && new_press,
        led_bits_reg != $past(led_bits_reg),
        "a new press did not change the LED bits")

    `KMSC_ASSERT_IMP(a_pin_pair, clk, rst_n, out_valid_reg,
        ($countones(enable_reg) == 2 || enable_reg == '0)
            && ((level_reg & ~enable_reg) == '0)
            && ($countones(level_reg) == 1 || enable_reg == '0),
        "LED pins are not a single driven pair")

    `KMSC_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(row_reg),
        "input stage lost a word while blocked")

endmodule

>>> tb/scan_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the keypad scanner: predicts each scan result word and compares it.
module scan_checker #(
    parameter int NUM_BUTTONS = kmsc_pkg::DEF_NUM_BUTTONS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    kmsc_in_if                           scan_in,
    kmsc_out_if                          scan_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [kmsc_pkg::PADDR_W-1:0] paddr,
    input  logic [kmsc_pkg::PDATA_W-1:0] pwdata,
    output int                           mismatches,
    output int                           words_pending
);

    typedef struct packed {
        logic [kmsc_pkg::SLOT_W-1:0] slot;
        logic                        toggled;
        logic [kmsc_pkg::COL_W-1:0]  cols;
        logic [kmsc_pkg::PIN_W-1:0]  pin_en;
        logic [kmsc_pkg::PIN_W-1:0]  pin_lvl;
        logic [kmsc_pkg::LEDS_W-1:0] leds;
    } scan_result_t;

    // Charlieplex pin numbers per slot, four bits per slot, slot 0 in the low nibble.
    localparam logic [47:0] PIN_A_NUMS = 48'h544_333_222_111;
    localparam logic [47:0] PIN_B_NUMS = 48'h665_654_543_432;

    logic [kmsc_pkg::SLOT_W-1:0] slot_ctr;
    logic [kmsc_pkg::LEDS_W-1:0] prev_pressed;
    logic [kmsc_pkg::LEDS_W-1:0] led_state;
    logic [kmsc_pkg::ACT_W-1:0]  reversed_slot;
    scan_result_t                expected_q[$];
    int                          fail_tally;

    // Advances the scanner model by one tick and returns the word it should produce.
    function automatic scan_result_t scan_tick(input logic [kmsc_pkg::ROW_W-1:0] rows);
        scan_result_t r;
        int           s;
        int           nxt;
        int           pa;
        int           pb;
        logic         down;
        r = '0;
        s = (slot_ctr >= NUM_BUTTONS) ? 0 : int'(slot_ctr);
        down = !rows[s / 4];
        if (down && !prev_pressed[s])
        begin
            led_state[s] = ~led_state[s];
            r.toggled = 1'b1;
        end
        prev_pressed[s] = down;
        pa = int'(PIN_A_NUMS[s*4 +: 4]);
        pb = int'(PIN_B_NUMS[s*4 +: 4]);
        if (led_state[s])
        begin
            r.pin_en[pa-1] = 1'b1;
            r.pin_en[pb-1] = 1'b1;
            // The selected button lights with reversed polarity: pin A high, pin B low.
            if (int'(reversed_slot) == s)
                r.pin_lvl[pa-1] = 1'b1;
            else
                r.pin_lvl[pb-1] = 1'b1;
        end
        nxt = (s + 1 >= NUM_BUTTONS) ? 0 : s + 1;
        slot_ctr = kmsc_pkg::SLOT_W'(nxt);
        r.slot = kmsc_pkg::SLOT_W'(s);
        r.cols = ~(kmsc_pkg::COL_W'(1) << (nxt % 4));
        r.leds = led_state;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_tally++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t want;
        if (!rst_n)
        begin
            slot_ctr = '0;
            prev_pressed = '0;
            led_state = '0;
            reversed_slot = kmsc_pkg::ACTIVE_NONE;
            expected_q.delete();
            fail_tally = 0;
            mismatches <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                    && kmsc_pkg::reg_index_t'(paddr[2]) == kmsc_pkg::REG_ACTIVE_BUTTON)
                reversed_slot = pwdata[kmsc_pkg::ACT_W-1:0];
            if (scan_in.valid && scan_in.ready)
                expected_q.push_back(scan_tick(scan_in.row_levels));
            if (scan_out.valid && scan_out.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none actual slot %h",
                             $time, scan_out.scanned_slot);
                    fail_tally++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("scanned_slot", want.slot, scan_out.scanned_slot);
                    check_field("toggled", want.toggled, scan_out.toggled);
                    check_field("column_drive", want.cols, scan_out.column_drive);
                    check_field("led_pin_enable", want.pin_en, scan_out.led_pin_enable);
                    check_field("led_pin_level", want.pin_lvl, scan_out.led_pin_level);
                    check_field("selected_leds", want.leds, scan_out.selected_leds);
                end
            end
            mismatches <= fail_tally;
            words_pending <= expected_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the keypad scanner testbench: clock, reset, stimulus, register writes and verdict.
module tb;

    localparam int NUM_BUTTONS  = kmsc_pkg::DEF_NUM_BUTTONS;
    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASE_WORDS  = 210;
    localparam int PHASE_COUNT  = 8;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [kmsc_pkg::PADDR_W-1:0] paddr;
    logic [kmsc_pkg::PDATA_W-1:0] pwdata;
    logic [kmsc_pkg::PDATA_W-1:0] prdata;
    logic                         pready;
    int                           mismatches;
    int                           words_pending;
    int                           quiet_cycles = 0;
    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    logic [kmsc_pkg::ROW_W-1:0]   last_rows = '1;

    kmsc_in_if  scan_in ();
    kmsc_out_if scan_out ();

    key_matrix_scan_charlieplex_leds #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_in  (scan_in),
        .scan_out (scan_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    scan_checker #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .scan_in       (scan_in),
        .scan_out      (scan_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        scan_out.ready <= ($urandom_range(99, 0) >= recv_stall_pct);

    // The run is declared hung when no word and no register write moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (scan_in.valid && scan_in.ready) || (scan_out.valid && scan_out.ready)
                || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_rows(input logic [kmsc_pkg::ROW_W-1:0] rows);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            scan_in.valid <= 1'b0;
            @(posedge clk);
        end
        scan_in.valid <= 1'b1;
        scan_in.row_levels <= rows;
        last_rows = rows;
        @(posedge clk);
        while (!scan_in.ready)
            @(posedge clk);
    endtask

    // Waits until every predicted word has come back, plus the pipeline depth.
    task automatic drain_results();
        scan_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (words_pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_active_button(input logic [kmsc_pkg::ACT_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {kmsc_pkg::REG_ACTIVE_BUTTON, 2'b00};
        pwdata <= kmsc_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        logic [kmsc_pkg::ACT_W-1:0] settings [PHASE_COUNT];
        logic [kmsc_pkg::ROW_W-1:0] rows;
        rst_n <= 1'b0;
        scan_in.valid <= 1'b0;
        scan_in.row_levels <= '1;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset setting (no reversed slot): press every slot,
        // hold the press, release, then press only the first row.
        repeat (NUM_BUTTONS) send_rows(3'b000);
        repeat (NUM_BUTTONS) send_rows(3'b000);
        repeat (NUM_BUTTONS) send_rows(3'b111);
        repeat (NUM_BUTTONS) send_rows(3'b110);
        drain_results();

        // Settings cover the first and last slot, no slot, and values past the last slot.
        settings[0] = '0;
        settings[1] = kmsc_pkg::ACT_W'(NUM_BUTTONS - 1);
        settings[2] = kmsc_pkg::ACTIVE_NONE;
        settings[3] = kmsc_pkg::ACT_W'(kmsc_pkg::MAX_BUTTONS);
        settings[4] = kmsc_pkg::ACT_W'(NUM_BUTTONS);
        settings[5] = kmsc_pkg::ACT_W'(254);
        settings[6] = kmsc_pkg::ACT_W'($urandom_range(NUM_BUTTONS - 1, 0));
        settings[7] = kmsc_pkg::ACT_W'($urandom_range(255, 0));

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_active_button(settings[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct = 28;
                    recv_stall_pct = 28;
                end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // Repeated row levels model held or released keys across scan rounds.
                if ($urandom_range(99, 0) < 35)
                    rows = last_rows;
                else
                    rows = kmsc_pkg::ROW_W'($urandom_range(7, 0));
                send_rows(rows);
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
